// ===== hw/rtl/wbs_pkg.sv =====
`default_nettype none

package wbs_pkg;

  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int IMG_W      = 13;
  localparam int SPEED_W    = 15;
  localparam int COUNT_W    = 25;
  localparam int SUM_W      = 36;
  localparam int CEN_W      = 12;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED    = 2'd2;

  localparam logic [IMG_W-1:0]   IMAGE_WIDTH_RESET = 13'd640;
  localparam logic [SPEED_W-1:0] SPEED_RESET       = 15'd2048;
  localparam logic [7:0]         WHITE_LEVEL       = 8'd255;
  localparam logic [CEN_W-1:0]   CEN_MAX           = '1;

  typedef enum logic [1:0] {
    STEER_STOP    = 2'd0,
    STEER_LEFT    = 2'd1,
    STEER_FORWARD = 2'd2,
    STEER_RIGHT   = 2'd3
  } steer_code_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    steer_code_t         steer_code;
    logic signed [15:0]  linear_speed;
    logic signed [15:0]  angular_speed;
    logic [COUNT_W-1:0]  white_count;
    logic [CEN_W-1:0]    centroid_column;
  } steer_t;

  typedef struct packed {
    logic accum;
    logic start;
    logic step;
    logic load_out;
  } wbs_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } wbs_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/white_blob_steering_unit.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_stall  pixel_t (red, green, blue, frame_end)
// steer     out        steer_valid / steer_stall  steer_t (code, speeds, count, centroid)
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// one pixel per cycle while accumulating
// a frame_end pixel is handled as one transfer, then 36 steps of the radix-2 divider, then the result
// load; pixel_stall stays high over the divider steps and the result state, also while the result
// waits for a free output register
// rst is synchronous and clears config to its defaults and all accumulators
// a held result does not stall pixels until the next frame end

module white_blob_steering_unit
  import wbs_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire pixel_t                pixel,
  output logic                       steer_valid,
  input  wire logic                  steer_stall,
  output steer_t                     steer,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  wbs_cmd_t    cmd;
  wbs_status_t sts;

  wbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .frame_end   (pixel.frame_end),
    .sts         (sts),
    .pixel_stall (pixel_stall),
    .cmd         (cmd)
  );

  wbs_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .pixel       (pixel),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .steer_valid (steer_valid),
    .steer_stall (steer_stall),
    .steer       (steer)
  );

  a_frame_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && pixel.frame_end) |=> pixel_stall)
    else $error("pixel accepted during division");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> steer_valid)
    else $error("loaded result not presented");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(steer_valid) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

  a_stop_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (steer_valid && steer.steer_code == STEER_STOP) |->
      (steer.linear_speed == '0 && steer.angular_speed == '0 &&
       steer.centroid_column == '0 && steer.white_count == '0))
    else $error("stop result carries nonzero fields");

endmodule

`default_nettype wire

// ===== hw/rtl/wbs_ctrl.sv =====
`default_nettype none

module wbs_ctrl
  import wbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pixel_valid,
  input  wire logic        frame_end,
  input  wire wbs_status_t sts,
  output logic             pixel_stall,
  output wbs_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd          = '0;
    cmd.accum    = (state == S_IDLE) && pixel_valid;
    cmd.start    = cmd.accum && frame_end;
    cmd.step     = (state == S_DIVIDE);
    cmd.load_out = (state == S_RESULT) && sts.out_free;
  end

  assign pixel_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (sts.div_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wbs_dp.sv =====
`default_nettype none

module wbs_dp
  import wbs_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire wbs_cmd_t              cmd,
  output wbs_status_t                sts,
  input  wire pixel_t                pixel,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       steer_valid,
  input  wire logic                  steer_stall,
  output steer_t                     steer
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > IMG_W) ? WW0 : IMG_W;

  logic [IMG_W-1:0]   image_width;
  logic [SPEED_W-1:0] forward_speed;
  logic [SPEED_W-1:0] turn_speed;

  logic [CW-1:0]      column_index;
  logic [COUNT_W-1:0] white_total;
  logic [SUM_W-1:0]   column_sum;

  logic [SUM_W-1:0]   div_q;
  logic [COUNT_W-1:0] div_rem;
  logic [COUNT_W-1:0] div_den;
  logic [STEP_W-1:0]  div_cnt;

  logic [WW-1:0]      img_ext;
  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      col_cur;
  logic [WW-1:0]      col_inc;
  logic [CW-1:0]      column_index_next;
  logic               is_white;
  logic [COUNT_W-1:0] white_total_next;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   column_sum_next;

  logic [COUNT_W:0]   rem_shift;
  logic               rem_ge;
  logic [COUNT_W:0]   rem_diff;

  logic [SUM_W+1:0]   mean_x3;
  logic               below_lo;
  logic               above_hi;
  steer_t             result;

  // effective width
  always_comb begin
    img_ext = WW'(image_width);
    w_eff   = img_ext;
    if (img_ext == '0) w_eff = WW'(1);
    else if (img_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
  end

  // column counter and accumulators
  always_comb begin
    col_cur = (WW'(column_index) >= w_eff) ? '0 : column_index;
    col_inc = WW'(col_cur) + WW'(1);
    column_index_next = (col_inc >= w_eff) ? '0 : col_inc[CW-1:0];

    is_white = (pixel.red == WHITE_LEVEL) && (pixel.green == WHITE_LEVEL) &&
               (pixel.blue == WHITE_LEVEL);

    white_total_next = white_total;
    column_sum_next  = column_sum;
    sum_wide         = (SUM_W+1)'(column_sum) + (SUM_W+1)'(col_cur);
    if (is_white) begin
      if (white_total != '1) white_total_next = white_total + COUNT_W'(1);
      column_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  // restoring divider step
  always_comb begin
    rem_shift = {div_rem, div_q[SUM_W-1]};
    rem_ge    = (rem_shift >= {1'b0, div_den});
    rem_diff  = rem_shift - {1'b0, div_den};
  end

  assign sts.div_last = (div_cnt == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free = !steer_valid || !steer_stall;

  // threshold compare without dividing width: 3*mean+3 <= w, 3*mean > 2*w
  always_comb begin
    mean_x3  = (SUM_W+2)'(div_q) + (SUM_W+2)'({div_q, 1'b0});
    below_lo = ((SUM_W+3)'(mean_x3) + (SUM_W+3)'(3)) <= (SUM_W+3)'(w_eff);
    above_hi = mean_x3 > (SUM_W+2)'({w_eff, 1'b0});

    result               = '0;
    result.steer_code    = STEER_STOP;
    result.white_count   = div_den;
    if (div_den != '0) begin
      result.centroid_column = (div_q > SUM_W'(CEN_MAX)) ? CEN_MAX : div_q[CEN_W-1:0];
      priority if (below_lo) begin
        result.steer_code    = STEER_LEFT;
        result.angular_speed = 16'(turn_speed);
      end else if (above_hi) begin
        result.steer_code    = STEER_RIGHT;
        result.angular_speed = 16'd0 - 16'(turn_speed);
      end else begin
        result.steer_code    = STEER_FORWARD;
        result.linear_speed  = 16'(forward_speed);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RESET;
      forward_speed <= SPEED_RESET;
      turn_speed    <= SPEED_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[IMG_W-1:0];
        CFG_FORWARD_SPEED: forward_speed <= cfg_data[SPEED_W-1:0];
        CFG_TURN_SPEED:    turn_speed    <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      white_total  <= '0;
      column_sum   <= '0;
    end else if (cmd.start) begin
      column_index <= '0;
      white_total  <= '0;
      column_sum   <= '0;
    end else if (cmd.accum) begin
      column_index <= column_index_next;
      white_total  <= white_total_next;
      column_sum   <= column_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_q   <= column_sum_next;
      div_den <= white_total_next;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.step) begin
      div_q   <= {div_q[SUM_W-2:0], rem_ge};
      div_rem <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
      div_cnt <= div_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_valid <= 1'b0;
    end else if (cmd.load_out) begin
      steer_valid <= 1'b1;
    end else if (!steer_stall) begin
      steer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      steer <= result;
    end
  end

endmodule

`default_nettype wire
